// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define AST_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define AST_CLK_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/cbyp_pkg.sv =====
// ---------------------------------------------------------------------------
// cbyp_pkg
// Types, constants and helpers for the camera basis pipeline.
// ---------------------------------------------------------------------------
package cbyp_pkg;

    localparam int DEF_FRAC_BITS = 15;
    localparam int INT_FRAC      = 30;
    localparam int VW            = 33;          // internal Q30 component width
    localparam int PW            = 2 * VW;      // full product width
    localparam int ANG_W         = 18;          // folded angle, 1/256 deg
    localparam int AW            = 29;          // CORDIC angle accumulator
    localparam int YAW_W         = 18;
    localparam int PITCH_W       = 17;
    localparam int CFG_W         = 16;
    localparam int WRAP_W        = 20;

    localparam int CORDIC_STEPS  = 24;
    localparam int CORDIC_LAT    = CORDIC_STEPS + 2;
    localparam int SQRT_STEPS    = 32;
    localparam int DIV_STEPS     = 32;
    localparam int NORM_LAT      = 2 + SQRT_STEPS + 1 + DIV_STEPS + 1;
    localparam int CROSS_LAT     = 2;
    localparam int LEN_W         = 32;

    localparam logic signed [WRAP_W-1:0] TURN_UNITS   = 20'sd92160;
    localparam logic signed [WRAP_W-1:0] HALF_TURN    = 20'sd46080;
    localparam logic signed [WRAP_W-1:0] QUARTER_TURN = 20'sd23040;
    localparam logic signed [WRAP_W-1:0] PITCH_LIMIT  = 20'sd22784;

    localparam logic signed [VW-1:0] CORDIC_GAIN = 33'sd652032874;
    localparam logic signed [PW-1:0] Q30_HALF    = PW'(64'sd536870912);

    typedef logic signed [VW-1:0] t_comp;
    typedef t_comp t_vec3 [3];

    typedef enum logic [1:0] {
        REG_UP_X = 2'd0,
        REG_UP_Y = 2'd1,
        REG_UP_Z = 2'd2
    } t_reg_idx;

    // arctangent of 2^-i in 2^-20 degree units
    function automatic logic signed [AW-1:0] atan_entry(input int i);
        logic signed [AW-1:0] a;
        unique case (i)
            0:  a = 29'sd47185920;
            1:  a = 29'sd27855475;
            2:  a = 29'sd14718068;
            3:  a = 29'sd7471121;
            4:  a = 29'sd3750058;
            5:  a = 29'sd1876857;
            6:  a = 29'sd938658;
            7:  a = 29'sd469357;
            8:  a = 29'sd234682;
            9:  a = 29'sd117342;
            10: a = 29'sd58671;
            11: a = 29'sd29335;
            12: a = 29'sd14668;
            13: a = 29'sd7334;
            14: a = 29'sd3667;
            15: a = 29'sd1833;
            16: a = 29'sd917;
            17: a = 29'sd458;
            18: a = 29'sd229;
            19: a = 29'sd115;
            20: a = 29'sd57;
            21: a = 29'sd29;
            22: a = 29'sd14;
            23: a = 29'sd7;
            default: a = '0;
        endcase
        return a;
    endfunction

    // Q60 product back to Q30, round half up
    function automatic t_comp rnd_q30(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] t;
        t = (p + Q30_HALF) >>> INT_FRAC;
        return t[VW-1:0];
    endfunction

endpackage

// ===== sv/camera_basis_from_yaw_pitch.sv =====
// ---------------------------------------------------------------------------
// camera_basis_from_yaw_pitch
// Orthonormal camera basis (front, right, up) from yaw and pitch angles.
// ---------------------------------------------------------------------------
// Fully pipelined: one transfer can start in every cycle and busy never rises.
// Each result appears on the outputs for one cycle with o_valid high. Its
// path runs through the input register, the CORDIC (24 rotation stages plus
// fold and sign), front scaling, then three normalizers (32 square-root
// stages and 32 divider stages each) with a cross product ahead of the
// second and third, and the output register. Results cannot be held off;
// take every o_valid cycle. Yaw wraps modulo 360 degrees, pitch clamps to
// +-89 degrees. When front is parallel to world up (cross shorter than one
// output LSB), o_degenerate is set and the right and up vectors come out as
// zero. World up is written over the APB port (byte addresses 0, 4, 8 for x,
// y, z) and must only be changed while no transfer is in flight.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module camera_basis_from_yaw_pitch import cbyp_pkg::*; #(
    parameter int VECTOR_FRACTION_BITS = DEF_FRAC_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // command side
    input  logic                            start,
    output logic                            busy,
    input  logic signed [YAW_W-1:0]         i_yaw_angle,
    input  logic signed [PITCH_W-1:0]       i_pitch_angle,
    // result side
    output logic                            o_valid,
    output logic signed [VECTOR_FRACTION_BITS:0] o_front_x,
    output logic signed [VECTOR_FRACTION_BITS:0] o_front_y,
    output logic signed [VECTOR_FRACTION_BITS:0] o_front_z,
    output logic signed [VECTOR_FRACTION_BITS:0] o_right_x,
    output logic signed [VECTOR_FRACTION_BITS:0] o_right_y,
    output logic signed [VECTOR_FRACTION_BITS:0] o_right_z,
    output logic signed [VECTOR_FRACTION_BITS:0] o_cam_up_x,
    output logic signed [VECTOR_FRACTION_BITS:0] o_cam_up_y,
    output logic signed [VECTOR_FRACTION_BITS:0] o_cam_up_z,
    output logic                            o_degenerate,
    // register port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [3:0]                      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    localparam int OW     = VECTOR_FRACTION_BITS + 1;
    localparam int SH     = INT_FRAC - VECTOR_FRACTION_BITS;
    localparam int SEG    = CROSS_LAT + NORM_LAT;   // cross + normalize
    localparam logic signed [VW:0] OUT_RND = (SH == 0) ? '0 : (VW+1)'(1) << (SH - 1);
    localparam logic signed [VW:0] OUT_HI  = ((VW+1)'(1) << VECTOR_FRACTION_BITS) - 1;
    localparam logic signed [VW:0] OUT_LO  = -((VW+1)'(1) << VECTOR_FRACTION_BITS);
    localparam logic [LEN_W-1:0]   DEGEN_THR = LEN_W'(1) << SH;

    // ---------------- register port ----------------
    logic signed [CFG_W-1:0] r_up_x, r_up_y, r_up_z;
    logic                    cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up_x <= 16'sd0;
            r_up_y <= 16'sd32767;
            r_up_z <= 16'sd0;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_UP_X: r_up_x <= pwdata[CFG_W-1:0];
                REG_UP_Y: r_up_y <= pwdata[CFG_W-1:0];
                REG_UP_Z: r_up_z <= pwdata[CFG_W-1:0];
                default:  ;   // unmapped, write dropped
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_UP_X: prdata = 32'(r_up_x);
            REG_UP_Y: prdata = 32'(r_up_y);
            REG_UP_Z: prdata = 32'(r_up_z);
            default:  prdata = '0;
        endcase
    end

    // ---------------- input stage: wrap yaw, clamp pitch ----------------
    assign busy = 1'b0;

    logic                     r_v0;
    logic signed [ANG_W-1:0]  r_yaw, r_pitch;
    logic signed [WRAP_W-1:0] n_yaw, n_pitch;

    always_comb begin
        n_yaw = WRAP_W'(i_yaw_angle);
        if (n_yaw < 0) begin
            n_yaw = n_yaw + TURN_UNITS;
        end
        if (n_yaw < 0) begin
            n_yaw = n_yaw + TURN_UNITS;
        end
        if (n_yaw >= TURN_UNITS) begin
            n_yaw = n_yaw - TURN_UNITS;
        end
        if (n_yaw > HALF_TURN) begin
            n_yaw = n_yaw - TURN_UNITS;
        end
        n_pitch = WRAP_W'(i_pitch_angle);
        priority if (n_pitch > PITCH_LIMIT) begin
            n_pitch = PITCH_LIMIT;
        end else if (n_pitch < -PITCH_LIMIT) begin
            n_pitch = -PITCH_LIMIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else begin
            r_v0 <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_yaw   <= n_yaw[ANG_W-1:0];
        r_pitch <= n_pitch[ANG_W-1:0];
    end

    // ---------------- sine / cosine ----------------
    logic  yc_vld, pc_vld;
    t_comp cy, sy, cp, sp;

    cbyp_cordic u_cordic_yaw (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v0),
        .i_angle (r_yaw),
        .o_valid (yc_vld),
        .o_cos   (cy),
        .o_sin   (sy)
    );

    cbyp_cordic u_cordic_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v0),
        .i_angle (r_pitch),
        .o_valid (pc_vld),
        .o_cos   (cp),
        .o_sin   (sp)
    );

    // ---------------- raw front: products, then round to Q30 ----------------
    logic                 r_vm, r_vr;
    logic signed [PW-1:0] r_pfx, r_pfz;
    t_comp                r_sp_m;
    t_vec3                r_raw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vm <= 1'b0;
            r_vr <= 1'b0;
        end else begin
            r_vm <= yc_vld && pc_vld;
            r_vr <= r_vm;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pfx    <= cy * cp;
        r_pfz    <= sy * cp;
        r_sp_m   <= sp;
        r_raw[0] <= rnd_q30(r_pfx);
        r_raw[1] <= r_sp_m;
        r_raw[2] <= rnd_q30(r_pfz);
    end

    logic             f_vld;
    t_vec3            front;
    logic [LEN_W-1:0] f_len;

    cbyp_norm u_norm_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vr),
        .i_vec   (r_raw),
        .o_valid (f_vld),
        .o_vec   (front),
        .o_len   (f_len)
    );

    // ---------------- right = normalize(front x world_up) ----------------
    t_vec3 wup;
    assign wup[0] = {{2{r_up_x[CFG_W-1]}}, r_up_x, 15'd0};
    assign wup[1] = {{2{r_up_y[CFG_W-1]}}, r_up_y, 15'd0};
    assign wup[2] = {{2{r_up_z[CFG_W-1]}}, r_up_z, 15'd0};

    logic                 r_c1v1, r_c1v2;
    logic signed [PW-1:0] r_c1p [6];
    t_vec3                r_rc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1v1 <= 1'b0;
            r_c1v2 <= 1'b0;
        end else begin
            r_c1v1 <= f_vld;
            r_c1v2 <= r_c1v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c1p[0] <= front[1] * wup[2];
        r_c1p[1] <= front[2] * wup[1];
        r_c1p[2] <= front[2] * wup[0];
        r_c1p[3] <= front[0] * wup[2];
        r_c1p[4] <= front[0] * wup[1];
        r_c1p[5] <= front[1] * wup[0];
        r_rc[0]  <= rnd_q30(r_c1p[0] - r_c1p[1]);
        r_rc[1]  <= rnd_q30(r_c1p[2] - r_c1p[3]);
        r_rc[2]  <= rnd_q30(r_c1p[4] - r_c1p[5]);
    end

    logic             rt_vld;
    t_vec3            right;
    logic [LEN_W-1:0] rt_len;

    cbyp_norm u_norm_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_c1v2),
        .i_vec   (r_rc),
        .o_valid (rt_vld),
        .o_vec   (right),
        .o_len   (rt_len)
    );

    // length below one output LSB means the squared cross is below threshold
    logic degen;
    assign degen = rt_len < DEGEN_THR;

    // ---------------- front delay line (to second cross and to output) ----
    t_vec3 r_fdly [2*SEG];

    always_ff @(posedge i_clk) begin
        r_fdly[0] <= front;
        for (int s = 1; s < 2 * SEG; s++) begin
            r_fdly[s] <= r_fdly[s-1];
        end
    end

    // ---------------- up = normalize(right x front) ----------------
    t_vec3 fa;
    assign fa = r_fdly[SEG-1];

    logic                 r_c2v1, r_c2v2;
    logic signed [PW-1:0] r_c2p [6];
    t_vec3                r_uc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c2v1 <= 1'b0;
            r_c2v2 <= 1'b0;
        end else begin
            r_c2v1 <= rt_vld;
            r_c2v2 <= r_c2v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c2p[0] <= right[1] * fa[2];
        r_c2p[1] <= right[2] * fa[1];
        r_c2p[2] <= right[2] * fa[0];
        r_c2p[3] <= right[0] * fa[2];
        r_c2p[4] <= right[0] * fa[1];
        r_c2p[5] <= right[1] * fa[0];
        r_uc[0]  <= rnd_q30(r_c2p[0] - r_c2p[1]);
        r_uc[1]  <= rnd_q30(r_c2p[2] - r_c2p[3]);
        r_uc[2]  <= rnd_q30(r_c2p[4] - r_c2p[5]);
    end

    logic             u_vld;
    t_vec3            upv;
    logic [LEN_W-1:0] u_len;

    cbyp_norm u_norm_up (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_c2v2),
        .i_vec   (r_uc),
        .o_valid (u_vld),
        .o_vec   (upv),
        .o_len   (u_len)
    );

    // right and degenerate flag wait for up
    t_vec3 r_rdly [SEG];
    logic  r_ddly [SEG];

    always_ff @(posedge i_clk) begin
        r_rdly[0] <= right;
        r_ddly[0] <= degen;
        for (int s = 1; s < SEG; s++) begin
            r_rdly[s] <= r_rdly[s-1];
            r_ddly[s] <= r_ddly[s-1];
        end
    end

    // ---------------- output: Q30 to QF, round and saturate ----------------
    function automatic logic [OW-1:0] to_out(input t_comp v);
        logic signed [VW:0] t;
        t = ((VW+1)'(v) + OUT_RND) >>> SH;
        if (t > OUT_HI) begin
            t = OUT_HI;
        end
        if (t < OUT_LO) begin
            t = OUT_LO;
        end
        return t[OW-1:0];
    endfunction

    logic          r_ov;
    logic [OW-1:0] r_of [3];
    logic [OW-1:0] r_or [3];
    logic [OW-1:0] r_ou [3];
    logic          r_odg;
    logic          dg;

    assign dg = r_ddly[SEG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= u_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_odg <= dg;
        for (int k = 0; k < 3; k++) begin
            r_of[k] <= to_out(r_fdly[2*SEG-1][k]);
            r_or[k] <= dg ? '0 : to_out(r_rdly[SEG-1][k]);
            r_ou[k] <= dg ? '0 : to_out(upv[k]);
        end
    end

    assign o_valid      = r_ov;
    assign o_front_x    = r_of[0];
    assign o_front_y    = r_of[1];
    assign o_front_z    = r_of[2];
    assign o_right_x    = r_or[0];
    assign o_right_y    = r_or[1];
    assign o_right_z    = r_or[2];
    assign o_cam_up_x   = r_ou[0];
    assign o_cam_up_y   = r_ou[1];
    assign o_cam_up_z   = r_ou[2];
    assign o_degenerate = r_odg;

    // lengths of front and up are not needed
    logic unused_len;
    assign unused_len = ^f_len ^ ^u_len;

    // ---------------- checks ----------------
    logic degen_out;
    logic rt_up_zero;

    assign degen_out  = o_valid && o_degenerate;
    assign rt_up_zero = (o_right_x == '0) && (o_right_y == '0) && (o_right_z == '0)
                     && (o_cam_up_x == '0) && (o_cam_up_y == '0) && (o_cam_up_z == '0);

    `AST_CLK(a_degen_zero, i_clk, i_rst_n, degen_out |-> rt_up_zero, "right/up set when degenerate")
    `AST_CLK_NR(a_rst_flush, i_clk, !i_rst_n |=> !o_valid, "result strobe right after reset")
    `AST_CLK(a_lanes_aligned, i_clk, i_rst_n, yc_vld == pc_vld, "yaw and pitch CORDIC out of step")

endmodule

// ===== sv/cbyp_cordic.sv =====
// ---------------------------------------------------------------------------
// cbyp_cordic
// Pipelined rotation-mode CORDIC: cosine and sine of a half-turn angle, Q30.
// ---------------------------------------------------------------------------
module cbyp_cordic import cbyp_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic signed [ANG_W-1:0] i_angle,
    output logic                    o_valid,
    output t_comp                   o_cos,
    output t_comp                   o_sin
);

    logic [CORDIC_LAT-1:0]  r_vld;
    t_comp                  r_x [CORDIC_STEPS+1];
    t_comp                  r_y [CORDIC_STEPS+1];
    logic signed [AW-1:0]   r_z [CORDIC_STEPS+1];
    logic                   r_neg [CORDIC_STEPS+1];
    t_comp                  r_cos;
    t_comp                  r_sin;

    logic signed [WRAP_W-1:0] n_ang;
    logic                     n_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[CORDIC_LAT-2:0], i_valid};
        end
    end

    // fold into +-90 degrees, flip sign afterwards
    always_comb begin
        n_ang = WRAP_W'(i_angle);
        n_neg = 1'b0;
        priority if (n_ang > QUARTER_TURN) begin
            n_ang = n_ang - HALF_TURN;
            n_neg = 1'b1;
        end else if (n_ang < -QUARTER_TURN) begin
            n_ang = n_ang + HALF_TURN;
            n_neg = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x[0]   <= CORDIC_GAIN;
        r_y[0]   <= '0;
        r_z[0]   <= AW'(n_ang) <<< 12;
        r_neg[0] <= n_neg;
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (r_z[i] >= 0) begin
                r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] - atan_entry(i);
            end else begin
                r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] + atan_entry(i);
            end
            r_neg[i+1] <= r_neg[i];
        end
    end

    always_ff @(posedge i_clk) begin
        r_cos <= r_neg[CORDIC_STEPS] ? -r_x[CORDIC_STEPS] : r_x[CORDIC_STEPS];
        r_sin <= r_neg[CORDIC_STEPS] ? -r_y[CORDIC_STEPS] : r_y[CORDIC_STEPS];
    end

    assign o_valid = r_vld[CORDIC_LAT-1];
    assign o_cos   = r_cos;
    assign o_sin   = r_sin;

    // residual angle is not needed past the last step
    logic unused_z;
    assign unused_z = ^r_z[CORDIC_STEPS];

endmodule

// ===== sv/cbyp_norm.sv =====
// ---------------------------------------------------------------------------
// cbyp_norm
// Pipelined 3-vector normalize: squares, sum, bit-per-stage square root,
// bit-per-stage rounded divide of each magnitude by the length.
// ---------------------------------------------------------------------------
module cbyp_norm import cbyp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  t_vec3            i_vec,
    output logic             o_valid,
    output t_vec3            o_vec,
    output logic [LEN_W-1:0] o_len
);

    logic [NORM_LAT-1:0] r_vld;

    // square stage
    logic [VW-1:0]   r_amag [3];
    logic            r_aneg [3];
    logic [63:0]     r_sq   [3];

    // root stages
    logic [63:0]     r_sv   [SQRT_STEPS+1];
    logic [63:0]     r_sr   [SQRT_STEPS+1];
    logic [VW-1:0]   r_smag [SQRT_STEPS+1][3];
    logic            r_sneg [SQRT_STEPS+1][3];

    // divide stages
    logic [LEN_W-1:0] r_dn   [DIV_STEPS+1];
    logic [31:0]      r_drem [DIV_STEPS+1][3];
    logic [31:0]      r_dlow [DIV_STEPS+1][3];
    logic [31:0]      r_dq   [DIV_STEPS+1][3];
    logic             r_dneg [DIV_STEPS+1][3];

    t_vec3            r_out;
    logic [LEN_W-1:0] r_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[NORM_LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        logic [VW-1:0] m;
        for (int k = 0; k < 3; k++) begin
            m          = i_vec[k][VW-1] ? VW'(-i_vec[k]) : VW'(i_vec[k]);
            r_amag[k] <= m;
            r_aneg[k] <= i_vec[k][VW-1];
            r_sq[k]   <= 64'(m) * 64'(m);
        end
    end

    always_ff @(posedge i_clk) begin
        r_sv[0] <= r_sq[0] + r_sq[1] + r_sq[2];
        r_sr[0] <= '0;
        for (int k = 0; k < 3; k++) begin
            r_smag[0][k] <= r_amag[k];
            r_sneg[0][k] <= r_aneg[k];
        end
    end

    for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_root
        localparam logic [63:0] SQ_BIT = 64'd1 << (62 - 2 * j);
        always_ff @(posedge i_clk) begin
            if (r_sv[j] >= r_sr[j] + SQ_BIT) begin
                r_sv[j+1] <= r_sv[j] - (r_sr[j] + SQ_BIT);
                r_sr[j+1] <= (r_sr[j] >> 1) + SQ_BIT;
            end else begin
                r_sv[j+1] <= r_sv[j];
                r_sr[j+1] <= r_sr[j] >> 1;
            end
            for (int k = 0; k < 3; k++) begin
                r_smag[j+1][k] <= r_smag[j][k];
                r_sneg[j+1][k] <= r_sneg[j][k];
            end
        end
    end

    // dividend = mag * 2^30 + len / 2
    always_ff @(posedge i_clk) begin
        logic [LEN_W-1:0] n;
        logic [63:0]      num;
        n = r_sr[SQRT_STEPS][LEN_W-1:0];
        r_dn[0] <= n;
        for (int k = 0; k < 3; k++) begin
            num = (64'(r_smag[SQRT_STEPS][k]) << INT_FRAC) + 64'(n >> 1);
            r_drem[0][k] <= num[63:32];
            r_dlow[0][k] <= num[31:0];
            r_dq[0][k]   <= '0;
            r_dneg[0][k] <= r_sneg[SQRT_STEPS][k];
        end
    end

    for (genvar t = 0; t < DIV_STEPS; t++) begin : g_div
        always_ff @(posedge i_clk) begin
            logic [32:0] trial;
            r_dn[t+1] <= r_dn[t];
            for (int k = 0; k < 3; k++) begin
                trial = {r_drem[t][k], r_dlow[t][k][31]};
                if (trial >= {1'b0, r_dn[t]}) begin
                    r_drem[t+1][k] <= 32'(trial - {1'b0, r_dn[t]});
                    r_dq[t+1][k]   <= {r_dq[t][k][30:0], 1'b1};
                end else begin
                    r_drem[t+1][k] <= trial[31:0];
                    r_dq[t+1][k]   <= {r_dq[t][k][30:0], 1'b0};
                end
                r_dlow[t+1][k] <= {r_dlow[t][k][30:0], 1'b0};
                r_dneg[t+1][k] <= r_dneg[t][k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        t_comp q;
        r_len <= r_dn[DIV_STEPS];
        for (int k = 0; k < 3; k++) begin
            q = VW'(r_dq[DIV_STEPS][k]);
            if (r_dn[DIV_STEPS] == '0) begin
                r_out[k] <= '0;
            end else begin
                r_out[k] <= r_dneg[DIV_STEPS][k] ? -q : q;
            end
        end
    end

    assign o_valid = r_vld[NORM_LAT-1];
    assign o_vec   = r_out;
    assign o_len   = r_len;

    // final remainders and spent dividend bits are dropped
    logic unused_tail;
    always_comb begin
        unused_tail = ^r_sv[SQRT_STEPS] ^ ^r_sr[SQRT_STEPS][63:LEN_W];
        for (int k = 0; k < 3; k++) begin
            unused_tail = unused_tail ^ ^r_drem[DIV_STEPS][k] ^ ^r_dlow[DIV_STEPS][k];
        end
    end

endmodule

// ===== dv/tb_camera_basis_from_yaw_pitch.sv =====
// ---------------------------------------------------------------------------
// tb_camera_basis_from_yaw_pitch
// Self-checking bench for the camera basis pipeline.
// ---------------------------------------------------------------------------
// Sends yaw/pitch commands with random gaps and predicts the front, right
// and up vectors with a bit-exact CORDIC / isqrt / divide model. A monitor
// compares every o_valid transfer with the oldest prediction. World up is
// reprogrammed over APB between phases while the pipeline is empty.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_camera_basis_from_yaw_pitch;
    import cbyp_pkg::*;

    localparam int FB = DEF_FRAC_BITS;
    localparam int PIPE_LAT = 238;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic signed [FB:0] fx, fy, fz, rx, ry, rz, ux, uy, uz;
        logic               degen;
    } t_basis;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [YAW_W-1:0]   i_yaw_angle = '0;
    logic signed [PITCH_W-1:0] i_pitch_angle = '0;
    logic o_valid;
    logic signed [FB:0] o_front_x, o_front_y, o_front_z;
    logic signed [FB:0] o_right_x, o_right_y, o_right_z;
    logic signed [FB:0] o_cam_up_x, o_cam_up_y, o_cam_up_z;
    logic o_degenerate;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    // predictor copy of the registers
    longint up_vec [3];
    t_basis basis_q [$];
    int     n_errors = 0;
    int     cycles = 0;
    bit     no_gaps = 0;

    camera_basis_from_yaw_pitch dut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ---- arithmetic helpers (floor shifts on longint are arithmetic) ----
    function automatic longint rshift(longint v, int s);
        if (s == 0) return v;
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint atan_val(int i);
        longint tbl [24] = '{47185920, 27855475, 14718068, 7471121, 3750058,
            1876857, 938658, 469357, 234682, 117342, 58671, 29335, 14668,
            7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7};
        return tbl[i];
    endfunction

    task automatic sin_cos(input longint a, output longint c, output longint s);
        longint x, y, z, dx, dy;
        bit flip;
        flip = 0;
        if (a > 23040) begin a -= 46080; flip = 1; end
        else if (a < -23040) begin a += 46080; flip = 1; end
        x = 652032874; y = 0; z = a * 4096;
        for (int i = 0; i < 24; i++) begin
            dx = y >>> i; dy = x >>> i;
            if (z >= 0) begin x -= dx; y += dy; z -= atan_val(i); end
            else begin x += dx; y -= dy; z += atan_val(i); end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    function automatic longint unsigned isqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0; b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin v -= r + b; r = (r >> 1) + b; end
            else r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned sumsq(longint v [3]);
        longint unsigned t = 0;
        for (int k = 0; k < 3; k++) t += longint'(v[k] * v[k]);
        return t;
    endfunction

    task automatic unit_vec(input longint v [3], output longint r [3]);
        longint unsigned n, m, q;
        n = isqrt(sumsq(v));
        for (int k = 0; k < 3; k++) begin
            if (n == 0) r[k] = 0;
            else begin
                m = v[k] < 0 ? -v[k] : v[k];
                q = ((m << 30) + n / 2) / n;
                r[k] = v[k] < 0 ? -longint'(q) : longint'(q);
            end
        end
    endtask

    task automatic cross3(input longint a [3], input longint b [3], output longint r [3]);
        r[0] = rshift(a[1] * b[2] - a[2] * b[1], 30);
        r[1] = rshift(a[2] * b[0] - a[0] * b[2], 30);
        r[2] = rshift(a[0] * b[1] - a[1] * b[0], 30);
    endtask

    function automatic logic signed [FB:0] to_q15(longint v);
        longint r;
        r = rshift(v, 30 - FB);
        if (r > (1 <<< FB) - 1) r = (1 <<< FB) - 1;
        if (r < -(1 <<< FB)) r = -(1 <<< FB);
        return r[FB:0];
    endfunction

    task automatic predict_basis(input logic signed [YAW_W-1:0] yw,
                                 input logic signed [PITCH_W-1:0] pt,
                                 output t_basis b);
        longint yaw, pitch, cy, sy, cp, sp;
        longint raw [3], fr [3], wu [3], rc [3], rt [3], uc [3], up [3];
        yaw = longint'(yw) % 92160;
        pitch = longint'(pt);
        if (yaw < 0) yaw += 92160;
        if (yaw > 46080) yaw -= 92160;
        if (pitch > 22784) pitch = 22784;
        if (pitch < -22784) pitch = -22784;
        sin_cos(yaw, cy, sy);
        sin_cos(pitch, cp, sp);
        raw[0] = rshift(cy * cp, 30);
        raw[1] = sp;
        raw[2] = rshift(sy * cp, 30);
        unit_vec(raw, fr);
        for (int k = 0; k < 3; k++) wu[k] = up_vec[k] * 32768;
        cross3(fr, wu, rc);
        b.degen = sumsq(rc) < (64'd1 << (2 * (30 - FB)));
        if (b.degen) begin
            rt = '{0, 0, 0}; up = '{0, 0, 0};
        end else begin
            unit_vec(rc, rt);
            cross3(rt, fr, uc);
            unit_vec(uc, up);
        end
        b.fx = to_q15(fr[0]); b.fy = to_q15(fr[1]); b.fz = to_q15(fr[2]);
        b.rx = to_q15(rt[0]); b.ry = to_q15(rt[1]); b.rz = to_q15(rt[2]);
        b.ux = to_q15(up[0]); b.uy = to_q15(up[1]); b.uz = to_q15(up[2]);
    endtask

    // ---- stimulus ----
    // start stays high after a transfer so the next one can follow at once;
    // idle cycles and register writes drop it
    task automatic send_angles(input logic signed [YAW_W-1:0] yw,
                               input logic signed [PITCH_W-1:0] pt);
        t_basis b;
        // random idle cycles ahead of the transfer
        while (!no_gaps && $urandom_range(99) < 31) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        predict_basis(yw, pt, b);
        start <= 1'b1;
        i_yaw_angle <= yw;
        i_pitch_angle <= pt;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        basis_q.push_back(b);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic signed [15:0] val);
        start <= 1'b0;
        wait (basis_q.size() == 0);
        repeat (PIPE_LAT + 4) @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= 4'(idx) << 2; pwdata <= 32'(unsigned'(val));
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        up_vec[idx] = val;
    endtask

    task automatic set_world_up(input logic signed [15:0] x, y, z);
        write_reg(REG_UP_X, x);
        write_reg(REG_UP_Y, y);
        write_reg(REG_UP_Z, z);
    endtask

    task automatic test_directed;
        send_angles(0, 0);
        send_angles(23040, 0);
        send_angles(-23040, 0);
        send_angles(46080, 0);
        send_angles(-46080, 0);
        send_angles(92160, 22784);
        send_angles(-92160, -22784);
        send_angles(18'sh1FFFF, 17'sh0FFFF);      // both fields out of range
        send_angles(-18'sh20000, -17'sh10000);
        send_angles(12345, 46080);
        send_angles(-777, -46080);
        send_angles(5000, 22785);
        send_angles(-5000, -22785);
    endtask

    task automatic test_degenerate;
        // world up along x: front at yaw 0 pitch 0 is parallel
        set_world_up(16'sh7FFF, 0, 0);
        send_angles(0, 0);
        send_angles(46080, 0);
        send_angles(23040, 0);
        set_world_up(0, 0, 0);                    // zero world up
        send_angles(1000, 2000);
        set_world_up(-16'sh8000, -16'sh8000, -16'sh8000);
        send_angles(11520, 9000);
        send_angles(0, 22784);
    endtask

    task automatic test_random(input int n);
        logic signed [YAW_W-1:0]   yw;
        logic signed [PITCH_W-1:0] pt;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(9) < 7) begin
                yw = $signed(18'($urandom_range(184320))) - 92160;
                pt = $signed(17'($urandom_range(92160))) - 46080;
            end else begin
                yw = 18'($urandom);
                pt = 17'($urandom);
            end
            send_angles(yw, pt);
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        n_errors++;
    endtask

    // ---- result monitor ----
    always @(posedge i_clk) begin
        t_basis e;
        if (i_rst_n && o_valid) begin
            if (basis_q.size() == 0) begin
                report_mismatch("unexpected transfer", 1, 0);
            end else begin
                e = basis_q.pop_front();
                if (o_front_x !== e.fx) report_mismatch("front_x", o_front_x, e.fx);
                if (o_front_y !== e.fy) report_mismatch("front_y", o_front_y, e.fy);
                if (o_front_z !== e.fz) report_mismatch("front_z", o_front_z, e.fz);
                if (o_right_x !== e.rx) report_mismatch("right_x", o_right_x, e.rx);
                if (o_right_y !== e.ry) report_mismatch("right_y", o_right_y, e.ry);
                if (o_right_z !== e.rz) report_mismatch("right_z", o_right_z, e.rz);
                if (o_cam_up_x !== e.ux) report_mismatch("cam_up_x", o_cam_up_x, e.ux);
                if (o_cam_up_y !== e.uy) report_mismatch("cam_up_y", o_cam_up_y, e.uy);
                if (o_cam_up_z !== e.uz) report_mismatch("cam_up_z", o_cam_up_z, e.uz);
                if (o_degenerate !== e.degen)
                    report_mismatch("degenerate", o_degenerate, e.degen);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        up_vec = '{0, 32767, 0};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed;
        test_degenerate;
        set_world_up(16'sh1234, -16'sh5678, 16'sh0ABC);
        test_random(400);
        no_gaps = 1;                              // back-to-back stretch
        test_random(300);
        no_gaps = 0;
        set_world_up(-16'sh8000, 16'sh7FFF, -16'sh8000);
        test_random(300);
        set_world_up(0, 16'sh7FFF, 0);
        test_random(300);
        start <= 1'b0;
        wait (basis_q.size() == 0);
        repeat (PIPE_LAT + 10) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
